### rtl/cscan_pkg.sv
// Shared constants, types and codes for the C-SCAN request scheduler.
`timescale 1ns / 1ps

package cscan_pkg;

   localparam int MaxRequests = 32;
   localparam int CountWidth  = $clog2(MaxRequests + 1);
   localparam int CylWidth    = 16;
   localparam int MoveWidth   = 18;
   localparam int SizeWidth   = 17;

   localparam logic KindLoad = 1'b0;
   localparam logic KindRun  = 1'b1;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_MARK,
      OP_ROTATE,
      OP_POP
   } cell_op_type;

   typedef struct packed {
      logic                valid;
      logic [CylWidth-1:0] value;
      logic                above;
      logic                gt;
   } link_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_HEAD,
      ST_UPPER,
      ST_TURN,
      ST_ZERO,
      ST_LOWER
   } state_type;

endpackage

### rtl/cscan_cell.sv
// One cell of the sorted request chain: a slot with its insert, mark, rotate and pop moves.
`timescale 1ns / 1ps

module cscan_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  cscan_pkg::cell_op_type       op,
   input  logic [cscan_pkg::CylWidth-1:0] cyl,
   input  cscan_pkg::link_type          left,
   input  cscan_pkg::link_type          right,
   input  cscan_pkg::link_type          wrap,
   output cscan_pkg::link_type          link
);
   import cscan_pkg::*;

   logic                valid_ff, valid_in;
   logic [CylWidth-1:0] value_ff, value_in;
   logic                above_ff, above_in;
   logic                gt;
   logic                tail;

   assign gt   = valid_ff && (value_ff > cyl);
   assign tail = valid_ff && !right.valid;

   assign link.valid = valid_ff;
   assign link.value = value_ff;
   assign link.above = above_ff;
   assign link.gt    = gt;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      above_in = above_ff;
      unique case (op)
         OP_HOLD: begin
         end
         OP_LOAD: begin
            // empty slots count as greater than anything
            if (!valid_ff || gt) begin
               value_in = left.gt ? left.value : cyl;
               valid_in = valid_ff | left.valid;
               above_in = 1'b0;
            end
         end
         OP_MARK: begin
            above_in = gt;
         end
         OP_ROTATE: begin
            if (valid_ff) begin
               if (tail) begin
                  value_in = wrap.value;
                  above_in = wrap.above;
               end else begin
                  value_in = right.value;
                  above_in = right.above;
               end
            end
         end
         OP_POP: begin
            valid_in = right.valid;
            value_in = right.value;
            above_in = right.above;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         above_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         above_ff <= above_in;
      end
      value_ff <= value_in;
   end

endmodule

### rtl/cscan_disk_request_scheduler.sv
// Top level of the C-SCAN scheduler: cell chain, sequencer, movement datapath, output register.
//
//   port group | dir | handshake        | word
//   req_       | in  | valid / stall    | kind, cylinder
//   rsp_       | out | valid / stall    | position, movement, dropped, last
//   csr_       | in  | valid / ready    | disk_size
//
// Loads may follow each other in consecutive cycles. A run first rotates each request
// at or below the head to the end of the chain, then gives requests + 3 results: the
// head, the requests above it in rising order, the turn point, cylinder zero and the
// requests below it. The upper sweep ends with a step that emits nothing.
// A result stall holds the sequencer; the input stalls while a run is in progress.
// Reset empties the chain and sets disk_size to 65536.
`timescale 1ns / 1ps

module cscan_disk_request_scheduler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic [cscan_pkg::CylWidth-1:0]  req_cylinder,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cscan_pkg::CylWidth-1:0]  rsp_position,
   output logic [cscan_pkg::MoveWidth-1:0] rsp_movement,
   output logic                            rsp_dropped,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cscan_pkg::SizeWidth-1:0] csr_disk_size
);
   import cscan_pkg::*;

   localparam link_type LeftEdge  = '{valid: 1'b1, value: '0, above: 1'b0, gt: 1'b0};
   localparam link_type RightEdge = '{valid: 1'b0, value: '0, above: 1'b0, gt: 1'b0};

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] rot_ff, rot_in;
   logic                  overflow_ff, overflow_in;
   logic [SizeWidth-1:0]  disk_size_ff;
   logic [CylWidth-1:0]   cur_ff, cur_in;
   logic [MoveWidth-1:0]  mv_ff, mv_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CylWidth-1:0]   rsp_position_ff;
   logic [MoveWidth-1:0]  rsp_movement_ff;
   logic                  rsp_dropped_ff;
   logic                  rsp_last_ff;

   link_type              links [MaxRequests];
   link_type              head_cell;
   cell_op_type           op;

   logic                  accept;
   logic                  full;
   logic                  out_free;
   logic                  rotate;
   logic                  upper_left;
   logic                  emit;
   logic                  emit_last;
   logic                  pop;
   logic [CylWidth-1:0]   emit_pos;
   logic [CylWidth-1:0]   seek_len;
   logic [CylWidth-1:0]   turn;
   logic [SizeWidth-1:0]  size_less;

   genvar g;
   generate
      for (g = 0; g < MaxRequests; g++) begin : g_cell
         link_type left_link, right_link;
         if (g == 0) begin : g_first
            assign left_link = LeftEdge;
         end else begin : g_mid_l
            assign left_link = links[g-1];
         end
         if (g == MaxRequests - 1) begin : g_last
            assign right_link = RightEdge;
         end else begin : g_mid_r
            assign right_link = links[g+1];
         end
         cscan_cell u_cell (
            .clock (clock),
            .reset (reset),
            .op    (op),
            .cyl   (req_cylinder),
            .left  (left_link),
            .right (right_link),
            .wrap  (links[0]),
            .link  (links[g])
         );
      end
   endgenerate

   assign head_cell  = links[0];
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign full       = (count_ff == CountWidth'(MaxRequests));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rotate     = head_cell.valid && !head_cell.above && (rot_ff != count_ff);
   assign upper_left = head_cell.valid && head_cell.above;
   assign csr_ready  = 1'b1;

   // turn point clamped to the cylinder range
   assign size_less = disk_size_ff - SizeWidth'(1);
   always_comb begin
      if (disk_size_ff == '0) begin
         turn = '0;
      end else if (disk_size_ff[SizeWidth-1] && (disk_size_ff[CylWidth-1:0] != '0)) begin
         turn = '1;
      end else begin
         turn = size_less[CylWidth-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && (req_kind == KindRun)) state_in = ST_ALIGN;
         ST_ALIGN: if (!rotate) state_in = ST_HEAD;
         ST_HEAD:  if (out_free) state_in = ST_UPPER;
         ST_UPPER: if (!upper_left) state_in = ST_TURN;
         ST_TURN:  if (out_free) state_in = ST_ZERO;
         ST_ZERO: begin
            if (out_free) state_in = (count_ff == '0) ? ST_IDLE : ST_LOWER;
         end
         ST_LOWER: begin
            if (out_free && (count_ff == CountWidth'(1))) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op        = OP_HOLD;
      emit      = 1'b0;
      emit_last = 1'b0;
      emit_pos  = cur_ff;
      pop       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KindRun) op = OP_MARK;
               else if (!full) op = OP_LOAD;
            end
         end
         ST_ALIGN: begin
            if (rotate) op = OP_ROTATE;
         end
         ST_HEAD: begin
            emit = out_free;
         end
         ST_UPPER: begin
            if (upper_left && out_free) begin
               emit     = 1'b1;
               emit_pos = head_cell.value;
               pop      = 1'b1;
               op       = OP_POP;
            end
         end
         ST_TURN: begin
            emit     = out_free;
            emit_pos = turn;
         end
         ST_ZERO: begin
            emit      = out_free;
            emit_pos  = '0;
            emit_last = (count_ff == '0);
         end
         ST_LOWER: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_pos  = head_cell.value;
               emit_last = (count_ff == CountWidth'(1));
               pop       = 1'b1;
               op        = OP_POP;
            end
         end
         default: begin
         end
      endcase
   end

   assign seek_len = (cur_ff > emit_pos) ? (cur_ff - emit_pos) : (emit_pos - cur_ff);

   always_comb begin
      count_in    = count_ff;
      rot_in      = rot_ff;
      overflow_in = overflow_ff;
      cur_in      = cur_ff;
      mv_in       = mv_ff;
      if (op == OP_LOAD) count_in = count_ff + CountWidth'(1);
      if (pop) count_in = count_ff - CountWidth'(1);
      if (accept && (req_kind == KindLoad) && full) overflow_in = 1'b1;
      if (accept && (req_kind == KindRun)) begin
         rot_in = '0;
         cur_in = req_cylinder;
         mv_in  = '0;
      end
      if (op == OP_ROTATE) rot_in = rot_ff + CountWidth'(1);
      if (emit) begin
         cur_in = emit_pos;
         mv_in  = mv_ff + {{(MoveWidth - CylWidth){1'b0}}, seek_len};
         if (emit_last) overflow_in = 1'b0;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rot_ff       <= '0;
         overflow_ff  <= 1'b0;
         disk_size_ff <= SizeWidth'(65536);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rot_ff       <= rot_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) disk_size_ff <= csr_disk_size;
      end
      cur_ff <= cur_in;
      mv_ff  <= mv_in;
      if (emit) begin
         rsp_position_ff <= emit_pos;
         rsp_movement_ff <= mv_in;
         rsp_dropped_ff  <= overflow_ff;
         rsp_last_ff     <= emit_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_movement = rsp_movement_ff;
   assign rsp_dropped  = rsp_dropped_ff;
   assign rsp_last     = rsp_last_ff;

endmodule
